// ===== src/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg: shared types and helpers for the segment capsule outline block
// Request payloads, the segment record handed from front to back, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_BAND_WIDTH   = 2'd0;
    localparam logic [1:0] REG_ROUND_START  = 2'd1;
    localparam logic [1:0] REG_ROUND_FINISH = 2'd2;

    localparam logic [31:0] BAND_WIDTH_RST = 32'd65536;
    localparam logic [63:0] PI_Q30         = 64'd3373259426;
    localparam int          TAYLOR_TERMS   = 20;
    localparam longint      ONE_Q30        = 64'sd1073741824;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] finish_x;
        logic signed [31:0] finish_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic               last_vertex;
        logic               degenerate;
    } out_t;

    // one classified segment, ready for vertex generation
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [33:0] c1x;
        logic signed [33:0] c1y;
        logic signed [33:0] c2x;
        logic signed [33:0] c2y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               rs;
        logic               rf;
        logic               degen;
    } seg_t;

    // shift right with rounding half away from zero
    function automatic logic signed [71:0] round_sh(input logic signed [71:0] v,
                                                    input int unsigned sh);
        logic [71:0] mag;
        logic        neg;
        neg = v[71];
        mag = neg ? 72'(-v) : 72'(v);
        mag = (mag + (72'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/scp_front.sv =====
// ----------------------------------------------------------------------------
// scp_front: segment intake and direction unit
// Classifies each request, normalizes it and derives the unit vector and
// the arc centres with an iterative square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire scp_pkg::in_t  in_data,
    input  wire logic [31:0]   band_width,
    input  wire logic          round_start,
    input  wire logic          round_finish,
    output logic               push,
    output scp_pkg::seg_t      push_data,
    input  wire logic          q_full
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQR  = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_ROOT = 4'd4;
    localparam logic [3:0] S_DSET = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_INS  = 4'd7;
    localparam logic [3:0] S_INSR = 4'd8;
    localparam logic [3:0] S_PUSH = 4'd9;

    logic               hold_valid_reg;
    scp_pkg::in_t       hold_reg;
    logic [3:0]         state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic [30:0]        a_reg, a_next, b_reg, b_next;
    logic               negx_reg, negx_next, negy_reg, negy_next;
    logic [61:0]        pa_reg, pa_next, pb_reg, pb_next;
    logic [63:0]        sq_reg, sq_next;
    logic [35:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [61:0]        na_reg, na_next, nb_reg, nb_next;
    logic [31:0]        ra_reg, ra_next, rb_reg, rb_next;
    logic [30:0]        qa_reg, qa_next, qb_reg, qb_next;
    logic signed [64:0] px_reg, px_next, py_reg, py_next;
    scp_pkg::seg_t      seg_reg, seg_next;
    logic               take;

    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay;
    logic [30:0]        m;
    logic [4:0]         sh;
    logic [35:0]        rem_t, trial;
    logic [32:0]        ta, tb;
    logic signed [31:0] vx, vy;
    logic signed [33:0] insx, insy;

    assign in_stall  = hold_valid_reg;
    assign push_data = seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            state_reg      <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && !in_stall)
                hold_valid_reg <= 1'b1;
            else if (take)
                hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            hold_reg <= in_data;
        step_reg <= step_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        na_reg   <= na_next;
        nb_reg   <= nb_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        seg_reg  <= seg_next;
    end

    always_comb
    begin
        dx    = 33'(hold_reg.start_x) - 33'(hold_reg.finish_x);
        dy    = 33'(hold_reg.start_y) - 33'(hold_reg.finish_y);
        ax    = dx[32] ? 33'(-dx) : 33'(dx);
        ay    = dy[32] ? 33'(-dy) : 33'(dy);
        m     = (a_reg > b_reg) ? a_reg : b_reg;
        sh    = 5'd16 >> step_reg[2:0];
        rem_t = {rem_reg[33:0], sq_reg[{step_reg, 1'b1}], sq_reg[{step_reg, 1'b0}]};
        trial = {2'b00, root_reg, 2'b01};
        ta    = {ra_reg, na_reg[step_reg]};
        tb    = {rb_reg, nb_reg[step_reg]};
        vx    = negx_reg ? -$signed({1'b0, qa_reg}) : $signed({1'b0, qa_reg});
        vy    = negy_reg ? -$signed({1'b0, qb_reg}) : $signed({1'b0, qb_reg});
        insx  = 34'(scp_pkg::round_sh(72'(px_reg), 31));
        insy  = 34'(scp_pkg::round_sh(72'(py_reg), 31));

        take       = 1'b0;
        push       = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        seg_next   = seg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (hold_valid_reg)
                begin
                    take         = 1'b1;
                    seg_next.sx  = hold_reg.start_x;
                    seg_next.sy  = hold_reg.start_y;
                    seg_next.fx  = hold_reg.finish_x;
                    seg_next.fy  = hold_reg.finish_y;
                    seg_next.rs  = round_start;
                    seg_next.rf  = round_finish;
                    seg_next.degen = 1'b0;
                    negx_next    = dx[32];
                    negy_next    = dy[32];
                    // largest magnitude is below 2^32, so one right shift at most
                    if (ax[31] || ay[31])
                    begin
                        a_next = ax[31:1];
                        b_next = ay[31:1];
                    end
                    else
                    begin
                        a_next = ax[30:0];
                        b_next = ay[30:0];
                    end
                    step_next = 5'd0;
                    if (!round_start && !round_finish)
                        state_next = S_IDLE;
                    else if (dx == 33'sd0 && dy == 33'sd0)
                    begin
                        seg_next.degen = 1'b1;
                        state_next     = S_PUSH;
                    end
                    else
                        state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // binary search for the leading one
                if ((m >> (5'd31 - sh)) == 31'd0)
                begin
                    a_next = a_reg << sh;
                    b_next = b_reg << sh;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd4)
                    state_next = S_SQR;
            end
            S_SQR:
            begin
                pa_next    = 62'(a_reg) * 62'(a_reg);
                pb_next    = 62'(b_reg) * 62'(b_reg);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sq_next    = 64'(pa_reg) + 64'(pb_reg);
                rem_next   = 36'd0;
                root_next  = 32'd0;
                step_next  = 5'd31;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {root_reg[30:0], 1'b0};
                end
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                    state_next = S_DSET;
            end
            S_DSET:
            begin
                na_next    = {a_reg, 30'd0} + 62'(root_reg >> 1);
                nb_next    = {b_reg, 30'd0} + 62'(root_reg >> 1);
                ra_next    = {1'b0, na_next[61:31]};
                rb_next    = {1'b0, nb_next[61:31]};
                qa_next    = 31'd0;
                qb_next    = 31'd0;
                step_next  = 5'd30;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (ta >= {1'b0, root_reg})
                begin
                    ra_next = 32'(ta - {1'b0, root_reg});
                    qa_next = {qa_reg[29:0], 1'b1};
                end
                else
                begin
                    ra_next = ta[31:0];
                    qa_next = {qa_reg[29:0], 1'b0};
                end
                if (tb >= {1'b0, root_reg})
                begin
                    rb_next = 32'(tb - {1'b0, root_reg});
                    qb_next = {qb_reg[29:0], 1'b1};
                end
                else
                begin
                    rb_next = tb[31:0];
                    qb_next = {qb_reg[29:0], 1'b0};
                end
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                    state_next = S_INS;
            end
            S_INS:
            begin
                seg_next.vx = vx;
                seg_next.vy = vy;
                px_next     = $signed({1'b0, band_width}) * vx;
                py_next     = $signed({1'b0, band_width}) * vy;
                state_next  = S_INSR;
            end
            S_INSR:
            begin
                seg_next.c1x = 34'(seg_reg.sx) - insx;
                seg_next.c1y = 34'(seg_reg.sy) - insy;
                seg_next.c2x = 34'(seg_reg.fx) + insx;
                seg_next.c2y = 34'(seg_reg.fy) + insy;
                state_next   = S_PUSH;
            end
            S_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/scp_fifo.sv =====
// ----------------------------------------------------------------------------
// scp_fifo: two-entry segment queue
// Decouples the direction unit from the vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire scp_pkg::seg_t push_data,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output scp_pkg::seg_t      head
);

    scp_pkg::seg_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== src/scp_back.sv =====
// ----------------------------------------------------------------------------
// scp_back: outline vertex generator
// Walks the cap arcs of one segment and emits one vertex per cycle while
// not stalled, through a four-stage rotate, scale and offset pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_back #(
    parameter int ARC_SIDES = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire scp_pkg::seg_t q_data,
    output logic               q_pop,
    input  wire logic [31:0]   band_width,
    output logic               out_valid,
    input  wire logic          out_stall,
    output scp_pkg::out_t      out_data
);

    localparam int KW = $clog2(ARC_SIDES + 1);
    localparam logic [KW-1:0] K_LAST = KW'(ARC_SIDES);

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_ARC   = 2'd1;
    localparam logic [1:0] PH_ARC2  = 2'd2;
    localparam logic [1:0] PH_TAIL  = 2'd3;

    typedef logic signed [31:0] tab_t [ARC_SIDES + 1];

    // cos or sin of k*pi/ARC_SIDES in Q2.30, truncated Taylor series
    function automatic tab_t make_tab(input bit want_sin);
        tab_t        tab;
        int unsigned j;
        bit          flip;
        logic [63:0] x, t;
        longint      cs, sn;
        for (int k = 0; k <= ARC_SIDES; k++)
        begin
            j    = k;
            flip = 1'b0;
            if (2 * k > ARC_SIDES)
            begin
                j    = ARC_SIDES - k;
                flip = 1'b1;
            end
            x  = 64'(j) * scp_pkg::PI_Q30 / 64'(ARC_SIDES);
            t  = 64'(scp_pkg::ONE_Q30);
            cs = scp_pkg::ONE_Q30;
            sn = 0;
            for (int N = 1; N <= scp_pkg::TAYLOR_TERMS; N++)
            begin
                t = ((t * x) >> 30) / 64'(N);
                if (N % 2 == 1)
                    sn = (((N / 2) % 2) == 1) ? sn - longint'(t) : sn + longint'(t);
                else
                    cs = (((N / 2) % 2) == 1) ? cs - longint'(t) : cs + longint'(t);
            end
            if (cs > scp_pkg::ONE_Q30)  cs = scp_pkg::ONE_Q30;
            if (cs < -scp_pkg::ONE_Q30) cs = -scp_pkg::ONE_Q30;
            if (sn > scp_pkg::ONE_Q30)  sn = scp_pkg::ONE_Q30;
            if (sn < -scp_pkg::ONE_Q30) sn = -scp_pkg::ONE_Q30;
            if (flip)
                cs = -cs;
            tab[k] = want_sin ? 32'(sn) : 32'(cs);
        end
        return tab;
    endfunction

    localparam tab_t COS_TAB = make_tab(1'b0);
    localparam tab_t SIN_TAB = make_tab(1'b1);

    logic [1:0]    phase_reg, phase_next;
    logic [KW-1:0] k_reg, k_next;

    // issue slot
    logic               en, issue;
    logic [KW-1:0]      k_sel;
    logic signed [33:0] bx, by;
    logic               neg, last;
    logic               both;

    // stage 1: rotation products
    logic               s1_valid_reg;
    logic signed [63:0] s1_pxs_reg, s1_pyc_reg, s1_pys_reg, s1_pxc_reg;
    logic signed [33:0] s1_bx_reg, s1_by_reg;
    logic               s1_neg_reg, s1_last_reg, s1_degen_reg;
    // stage 2: rotated unit direction
    logic               s2_valid_reg;
    logic signed [33:0] s2_ux_reg, s2_uy_reg;
    logic signed [33:0] s2_bx_reg, s2_by_reg;
    logic               s2_neg_reg, s2_last_reg, s2_degen_reg;
    // stage 3: scaled by band width
    logic               s3_valid_reg;
    logic signed [66:0] s3_mx_reg, s3_my_reg;
    logic signed [33:0] s3_bx_reg, s3_by_reg;
    logic               s3_neg_reg, s3_last_reg, s3_degen_reg;
    // output register
    logic               out_valid_reg;
    scp_pkg::out_t      out_reg;

    logic signed [35:0] ox, oy, vtx_x, vtx_y;

    assign en        = !(out_valid_reg && out_stall);
    assign issue     = en && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign both      = q_data.rs && q_data.rf;

    always_comb
    begin
        phase_next = phase_reg;
        k_next     = k_reg;
        k_sel      = k_reg;
        bx         = q_data.c1x;
        by         = q_data.c1y;
        neg        = 1'b0;
        last       = 1'b0;
        q_pop      = 1'b0;
        if (q_data.degen)
        begin
            bx    = 34'sd0;
            by    = 34'sd0;
            last  = 1'b1;
            q_pop = issue;
        end
        else
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    k_sel      = '0;
                    phase_next = PH_ARC;
                    k_next     = '0;
                    if (both)
                        k_next = KW'(1);
                    else if (q_data.rs)
                    begin
                        bx = 34'(q_data.fx);
                        by = 34'(q_data.fy);
                    end
                    else
                    begin
                        bx  = 34'(q_data.sx);
                        by  = 34'(q_data.sy);
                        neg = 1'b1;
                    end
                end
                PH_ARC:
                begin
                    if (!q_data.rs)
                    begin
                        bx  = q_data.c2x;
                        by  = q_data.c2y;
                        neg = 1'b1;
                    end
                    k_next = k_reg + KW'(1);
                    if (k_reg == K_LAST)
                    begin
                        k_next     = '0;
                        phase_next = both ? PH_ARC2 : PH_TAIL;
                    end
                end
                PH_ARC2:
                begin
                    bx     = q_data.c2x;
                    by     = q_data.c2y;
                    neg    = 1'b1;
                    k_next = k_reg + KW'(1);
                    if (k_reg == K_LAST)
                    begin
                        k_next     = '0;
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    k_sel      = '0;
                    last       = 1'b1;
                    q_pop      = issue;
                    phase_next = PH_FIRST;
                    k_next     = '0;
                    if (both)
                    begin
                        bx = q_data.c1x;
                        by = q_data.c1y;
                    end
                    else if (q_data.rs)
                    begin
                        bx  = 34'(q_data.fx);
                        by  = 34'(q_data.fy);
                        neg = 1'b1;
                    end
                    else
                    begin
                        bx = 34'(q_data.sx);
                        by = 34'(q_data.sy);
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_comb
    begin
        ox    = 36'(scp_pkg::round_sh(72'(s3_mx_reg), 31));
        oy    = 36'(scp_pkg::round_sh(72'(s3_my_reg), 31));
        vtx_x = s3_neg_reg ? 36'(s3_bx_reg) - ox : 36'(s3_bx_reg) + ox;
        vtx_y = s3_neg_reg ? 36'(s3_by_reg) - oy : 36'(s3_by_reg) + oy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (issue && !q_data.degen)
            begin
                phase_reg <= phase_next;
                k_reg     <= k_next;
            end
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pxs_reg   <= q_data.vx * SIN_TAB[k_sel];
            s1_pyc_reg   <= q_data.vy * COS_TAB[k_sel];
            s1_pys_reg   <= q_data.vy * SIN_TAB[k_sel];
            s1_pxc_reg   <= q_data.vx * COS_TAB[k_sel];
            s1_bx_reg    <= bx;
            s1_by_reg    <= by;
            s1_neg_reg   <= neg;
            s1_last_reg  <= last;
            s1_degen_reg <= q_data.degen;

            s2_ux_reg    <= 34'(scp_pkg::round_sh(72'(65'(s1_pxs_reg) + 65'(s1_pyc_reg)), 30));
            s2_uy_reg    <= 34'(scp_pkg::round_sh(72'(65'(s1_pys_reg) - 65'(s1_pxc_reg)), 30));
            s2_bx_reg    <= s1_bx_reg;
            s2_by_reg    <= s1_by_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_last_reg  <= s1_last_reg;
            s2_degen_reg <= s1_degen_reg;

            s3_mx_reg    <= $signed({1'b0, band_width}) * s2_ux_reg;
            s3_my_reg    <= $signed({1'b0, band_width}) * s2_uy_reg;
            s3_bx_reg    <= s2_bx_reg;
            s3_by_reg    <= s2_by_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_last_reg  <= s2_last_reg;
            s3_degen_reg <= s2_degen_reg;

            out_reg.vertex_x    <= s3_degen_reg ? 32'sd0 : scp_pkg::sat32(vtx_x);
            out_reg.vertex_y    <= s3_degen_reg ? 32'sd0 : scp_pkg::sat32(vtx_y);
            out_reg.last_vertex <= s3_last_reg;
            out_reg.degenerate  <= s3_degen_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/segment_capsule_outline.sv =====
// ----------------------------------------------------------------------------
// segment_capsule_outline: rounded band outline of a line segment
// Turns each segment request into the closed outline polygon of a band
// with half-circle or square ends.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  in        | input     | in_valid/in_stall  | scp_pkg::in_t (two endpoints)
//  out       | output    | out_valid/out_stall| scp_pkg::out_t (one vertex)
//  cfg       | input     | APB psel/penable   | band_width, round_start/finish
//
//  in the direction unit a segment takes 5 normalize steps, 32 square root
//  steps and 31 divide steps, one bit per cycle
//  the vertex generator then gives one vertex per cycle while the output
//  is not stalled, 23 for two round ends, 13 for one, 1 for coincident
//  endpoints, none with both caps off; a two-entry queue lets the next
//  segment be worked while vertices drain; reset is asynchronous and
//  clears control state; an output stall freezes the whole vertex pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module segment_capsule_outline #(
    parameter int ARC_SIDES = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire scp_pkg::in_t               in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output scp_pkg::out_t                   out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [scp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [31:0]   band_width_reg;
    logic          round_start_reg, round_finish_reg;
    logic          cfg_wr;
    logic          q_push, q_pop, q_full, q_not_empty;
    scp_pkg::seg_t q_in, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_width_reg   <= scp_pkg::BAND_WIDTH_RST;
            round_start_reg  <= 1'b1;
            round_finish_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                scp_pkg::REG_BAND_WIDTH:   band_width_reg   <= pwdata;
                scp_pkg::REG_ROUND_START:  round_start_reg  <= pwdata[0];
                scp_pkg::REG_ROUND_FINISH: round_finish_reg <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            scp_pkg::REG_BAND_WIDTH:   prdata = band_width_reg;
            scp_pkg::REG_ROUND_START:  prdata = {31'd0, round_start_reg};
            scp_pkg::REG_ROUND_FINISH: prdata = {31'd0, round_finish_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    scp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .band_width   (band_width_reg),
        .round_start  (round_start_reg),
        .round_finish (round_finish_reg),
        .push         (q_push),
        .push_data    (q_in),
        .q_full       (q_full)
    );

    scp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    scp_back #(
        .ARC_SIDES (ARC_SIDES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_data     (q_head),
        .q_pop      (q_pop),
        .band_width (band_width_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("segment queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("segment queue read while empty");

    a_degen_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.degenerate) |->
            (out_data.last_vertex && out_data.vertex_x == 32'sd0
             && out_data.vertex_y == 32'sd0))
        else $error("degenerate vertex not a lone zero vertex");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_segment_capsule_outline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_capsule_outline: self-checking bench for the capsule outliner
// Sends segment requests under random idling on both sides and compares
// every emitted outline vertex with an in-bench fixed-point predictor.
// Covers all cap settings, width extremes, coincident ends and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_capsule_outline;

    localparam int     SIDES       = 10;
    localparam int     CLK_HALF    = 2;
    localparam int     SETTLE      = 150;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam longint Q30         = 64'sd1073741824;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    scp_pkg::in_t                in_data;
    logic                        out_valid;
    logic                        out_stall;
    scp_pkg::out_t               out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [scp_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // bench copy of the register file
    logic [31:0]         cur_width;
    logic                cur_rstart;
    logic                cur_rfinish;

    scp_pkg::out_t       vertex_queue[$];
    int                  err_count;
    int                  seg_count;
    int                  vertex_count;
    int                  degen_count;
    longint              cycle_count;
    int                  stall_left;
    bit                  stall_quiet;
    bit                  gap_quiet;

    segment_capsule_outline #(.ARC_SIDES(SIDES)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint rnd_shift(input longint v, input int sh);
        bit                    neg;
        longint unsigned       mag;
        neg = v < 0;
        mag = neg ? longint'(-v) : longint'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitpos;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= res + bitpos)
            begin
                v = v - (res + bitpos);
                res = (res >> 1) + bitpos;
            end
            else
                res = res >> 1;
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    // cos/sin of k*pi/SIDES in Q2.30 by truncated taylor series
    task automatic step_trig(input int k, output longint c, output longint s);
        int              j;
        bit              flip;
        longint unsigned x;
        longint unsigned t;
        longint          cs;
        longint          sn;
        j = k;
        flip = 0;
        if (2 * k > SIDES)
        begin
            j = SIDES - k;
            flip = 1;
        end
        x = longint'(j) * scp_pkg::PI_Q30 / SIDES;
        t = Q30;
        cs = Q30;
        sn = 0;
        for (int n = 1; n <= 20; n++)
        begin
            t = ((t * x) >> 30) / n;
            if (n % 2 == 1)
                sn = ((n >> 1) & 1) ? sn - longint'(t) : sn + longint'(t);
            else
                cs = ((n >> 1) & 1) ? cs - longint'(t) : cs + longint'(t);
        end
        if (cs > Q30) cs = Q30;
        if (cs < -Q30) cs = -Q30;
        if (sn > Q30) sn = Q30;
        if (sn < -Q30) sn = -Q30;
        c = flip ? -cs : cs;
        s = sn;
    endtask

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic push_vertex(input longint x, input longint y, input bit last,
                               input bit degen);
        scp_pkg::out_t v;
        v.vertex_x    = clip32(x);
        v.vertex_y    = clip32(y);
        v.last_vertex = last;
        v.degenerate  = degen;
        vertex_queue.insert(vertex_queue.size(), v);
    endtask

    task automatic predict_outline(input scp_pkg::in_t seg);
        longint          sx, sy, fx, fy, dx, dy, vx, vy, bw;
        longint          c, s, ux, uy, insx, insy, c1x, c1y, c2x, c2y;
        longint          ox[SIDES+1];
        longint          oy[SIDES+1];
        longint unsigned a, b, m, r;
        sx = seg.start_x;
        sy = seg.start_y;
        fx = seg.finish_x;
        fy = seg.finish_y;
        dx = sx - fx;
        dy = sy - fy;
        bw = longint'({32'd0, cur_width});
        if (!cur_rstart && !cur_rfinish)
            return;
        if (dx == 0 && dy == 0)
        begin
            push_vertex(0, 0, 1'b1, 1'b1);
            return;
        end
        a = dx < 0 ? -dx : dx;
        b = dy < 0 ? -dy : dy;
        m = a > b ? a : b;
        while (m >= (64'd1 << 31))
        begin
            a = a >> 1; b = b >> 1; m = m >> 1;
        end
        while (m < (64'd1 << 30))
        begin
            a = a << 1; b = b << 1; m = m << 1;
        end
        r = int_sqrt(a * a + b * b);
        vx = longint'(((a << 30) + (r >> 1)) / r);
        vy = longint'(((b << 30) + (r >> 1)) / r);
        if (dx < 0) vx = -vx;
        if (dy < 0) vy = -vy;
        for (int k = 0; k <= SIDES; k++)
        begin
            step_trig(k, c, s);
            ux = rnd_shift(vx * s + vy * c, 30);
            uy = rnd_shift(vy * s - vx * c, 30);
            ox[k] = rnd_shift(bw * ux, 31);
            oy[k] = rnd_shift(bw * uy, 31);
        end
        insx = rnd_shift(bw * vx, 31);
        insy = rnd_shift(bw * vy, 31);
        c1x = sx - insx; c1y = sy - insy;
        c2x = fx + insx; c2y = fy + insy;
        if (cur_rstart && cur_rfinish)
        begin
            for (int k = 0; k <= SIDES; k++)
                push_vertex(c1x + ox[k], c1y + oy[k], 1'b0, 1'b0);
            for (int k = 0; k <= SIDES; k++)
                push_vertex(c2x - ox[k], c2y - oy[k], 1'b0, 1'b0);
            push_vertex(c1x + ox[0], c1y + oy[0], 1'b1, 1'b0);
        end
        else if (cur_rstart)
        begin
            push_vertex(fx + ox[0], fy + oy[0], 1'b0, 1'b0);
            for (int k = 0; k <= SIDES; k++)
                push_vertex(c1x + ox[k], c1y + oy[k], 1'b0, 1'b0);
            push_vertex(fx - ox[0], fy - oy[0], 1'b1, 1'b0);
        end
        else
        begin
            push_vertex(sx - ox[0], sy - oy[0], 1'b0, 1'b0);
            for (int k = 0; k <= SIDES; k++)
                push_vertex(c2x - ox[k], c2y - oy[k], 1'b0, 1'b0);
            push_vertex(sx + ox[0], sy + oy[0], 1'b1, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- drivers

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_segment(input scp_pkg::in_t seg);
        int gap;
        in_valid = 1'b1;
        in_data  = seg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_outline(seg);
        seg_count++;
        @(negedge clk);
        gap = gap_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // wait out everything in flight, including requests that give no vertex
    task automatic drain();
        in_valid = 1'b0;
        while (vertex_queue.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = scp_pkg::ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            scp_pkg::REG_BAND_WIDTH:   cur_width   = value;
            scp_pkg::REG_ROUND_START:  cur_rstart  = value[0];
            scp_pkg::REG_ROUND_FINISH: cur_rfinish = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_caps(input logic [31:0] width, input bit rs, input bit rf);
        drain();
        reg_write(scp_pkg::REG_BAND_WIDTH, width);
        reg_write(scp_pkg::REG_ROUND_START, {31'd0, rs});
        reg_write(scp_pkg::REG_ROUND_FINISH, {31'd0, rf});
    endtask

    function automatic scp_pkg::in_t mk_seg(input int sx, input int sy, input int fx,
                                            input int fy);
        scp_pkg::in_t s;
        s.start_x  = sx;
        s.start_y  = sy;
        s.finish_x = fx;
        s.finish_y = fy;
        return s;
    endfunction

    function automatic scp_pkg::in_t random_seg();
        scp_pkg::in_t s;
        int           kind;
        kind = $urandom_range(0, 9);
        s = mk_seg($urandom, $urandom, $urandom, $urandom);
        if (kind < 4)
        begin
            // modest coordinates so most outlines stay in range
            s.start_x  = $signed($urandom_range(0, 2097151)) - 1048576;
            s.start_y  = $signed($urandom_range(0, 2097151)) - 1048576;
            s.finish_x = $signed($urandom_range(0, 2097151)) - 1048576;
            s.finish_y = $signed($urandom_range(0, 2097151)) - 1048576;
        end
        else if (kind == 6)
        begin
            s.finish_x = s.start_x;
            s.finish_y = s.start_y;
        end
        else if (kind == 7)
            s.finish_y = s.start_y;
        else if (kind == 8)
            s.finish_x = s.start_x + $signed($urandom_range(0, 6)) - 3;
        return s;
    endfunction

    function automatic logic [31:0] random_width();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return $urandom_range(1, 32'h0010_0000);
        if (roll < 8)
            return $urandom;
        return 32'(roll - 8) * 32'hffff_ffff;
    endfunction

    // ---------------------------------------------------------------- checker

    always @(negedge clk)
    begin
        if (!rst_n || stall_quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        scp_pkg::out_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_segment_capsule_outline: done, errors");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (vertex_queue.size() == 0)
            begin
                $error("vertex with no request pending: x=%0d y=%0d",
                       out_data.vertex_x, out_data.vertex_y);
                err_count++;
            end
            else
            begin
                want = vertex_queue.pop_front();
                vertex_count++;
                if (want.degenerate)
                    degen_count++;
                if (out_data.vertex_x !== want.vertex_x)
                begin
                    $error("vertex_x expected %0d got %0d", want.vertex_x, out_data.vertex_x);
                    err_count++;
                end
                if (out_data.vertex_y !== want.vertex_y)
                begin
                    $error("vertex_y expected %0d got %0d", want.vertex_y, out_data.vertex_y);
                    err_count++;
                end
                if (out_data.last_vertex !== want.last_vertex)
                begin
                    $error("last_vertex expected %0b got %0b",
                           want.last_vertex, out_data.last_vertex);
                    err_count++;
                end
                if (out_data.degenerate !== want.degenerate)
                begin
                    $error("degenerate expected %0b got %0b",
                           want.degenerate, out_data.degenerate);
                    err_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_default_caps();
        send_segment(mk_seg(0, 0, 32'sd655360, 0));
        send_segment(mk_seg(0, 0, 0, -32'sd655360));
        send_segment(mk_seg(32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536));
        send_segment(mk_seg(32'sd12345, -32'sd999, 32'sd12345, -32'sd999));
        send_segment(mk_seg(0, 0, 0, 0));
        send_segment(mk_seg(0, 0, 1, 0));
        send_segment(mk_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
        send_segment(mk_seg(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    endtask

    task automatic test_width_extremes();
        set_caps(32'hffff_ffff, 1'b1, 1'b1);
        send_segment(mk_seg(0, 0, 32'sd100, 32'sd37));
        send_segment(mk_seg(32'sh7fff0000, 0, 32'sh7ff00000, 32'sd5));
        send_segment(mk_seg(-32'sd5, 32'sh80000000, 32'sd5, 32'sh80000000));
        set_caps(32'd0, 1'b1, 1'b1);
        send_segment(mk_seg(32'sd1000, 32'sd2000, -32'sd3000, 32'sd4000));
        send_segment(mk_seg(32'sh7fffffff, 0, 32'sh7fffffff, 32'sh7fffffff));
    endtask

    task automatic test_single_cap();
        set_caps(32'h0002_0000, 1'b1, 1'b0);
        send_segment(mk_seg(0, 0, 32'sd327680, 32'sd196608));
        send_segment(mk_seg(-32'sd70000, 32'sd5, -32'sd70000, 32'sd5));
        send_segment(mk_seg(32'sh80000000, 0, 32'sh7fffffff, 0));
        set_caps(32'h0002_0000, 1'b0, 1'b1);
        send_segment(mk_seg(0, 0, 32'sd327680, 32'sd196608));
        send_segment(mk_seg(32'sd9, 32'sd9, 32'sd9, 32'sd9));
        send_segment(mk_seg(0, 32'sh7fffffff, 0, 32'sh80000000));
    endtask

    task automatic test_no_caps();
        set_caps(32'h0001_0000, 1'b0, 1'b0);
        send_segment(mk_seg(0, 0, 32'sd65536, 0));
        send_segment(mk_seg(32'sd7, 32'sd7, 32'sd7, 32'sd7));
        send_segment(random_seg());
    endtask

    task automatic test_random_segments();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: set_caps(random_width(), 1'b1, 1'b1);
                1: set_caps(random_width(), 1'b1, 1'b0);
                2: set_caps(random_width(), 1'b0, 1'b1);
                default: set_caps(random_width(), 1'b1, 1'b1);
            endcase
            gap_quiet   = (phase == 3);
            stall_quiet = (phase == 3) || (phase == 6);
            for (int i = 0; i < 42; i++)
            begin
                send_segment(random_seg());
                // let the block empty completely once in the middle of a phase
                if (phase == 5 && i == 20)
                begin
                    in_valid = 1'b0;
                    while (vertex_queue.size() > 0)
                        @(negedge clk);
                end
            end
        end
        gap_quiet   = 0;
        stall_quiet = 0;
        // a short run with both caps off, then back to a rounded setting
        set_caps(random_width(), 1'b0, 1'b0);
        repeat (4) send_segment(random_seg());
        set_caps(32'h0001_0000, 1'b1, 1'b1);
        repeat (10) send_segment(random_seg());
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cur_width   = scp_pkg::BAND_WIDTH_RST;
        cur_rstart  = 1'b1;
        cur_rfinish = 1'b1;
        err_count   = 0;
        seg_count   = 0;
        vertex_count = 0;
        degen_count = 0;
        cycle_count = 0;
        stall_left  = 0;
        stall_quiet = 0;
        gap_quiet   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_caps();
        test_width_extremes();
        test_single_cap();
        test_no_caps();
        test_random_segments();
        drain();

        $display("sent %0d segment requests, checked %0d vertices (%0d degenerate)",
                 seg_count, vertex_count, degen_count);
        $display("cap settings: both, start only, finish only, none; widths 0 to max");
        if (err_count == 0)
            $display("tb_segment_capsule_outline: done, clean");
        else
            $display("tb_segment_capsule_outline: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/scp_pkg.sv
src/scp_front.sv
src/scp_fifo.sv
src/scp_back.sv
src/segment_capsule_outline.sv
tb/sv/tb_segment_capsule_outline.sv
